### hdl/rw_pkg.sv
// rw_pkg: shared sizes, types and helpers of the repetition watchdog.
// Used by rw_key_tbl and repetition_watchdog.
package rw_pkg;

    localparam int NUM_KEYS    = 64;
    localparam int HIST_DEPTH  = 64;
    localparam int MIN_HISTORY = 10;
    localparam int PERIOD_FIRST = 2;
    localparam int PERIOD_LAST  = 5;

    localparam int KEY_W   = 6;
    localparam int HASH_W  = 64;
    localparam int CNT_W   = 17;
    localparam int SLOT_W  = $clog2(HIST_DEPTH);
    localparam int LEN_W   = $clog2(HIST_DEPTH + 1);
    localparam int ADDR_W  = $clog2(NUM_KEYS * HIST_DEPTH);
    localparam int KIDX_W  = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    localparam logic [CNT_W-1:0] COUNT_SAT = 17'd65536;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_LIMIT   = 2'd1;
    localparam logic [1:0] ST_PATTERN = 2'd2;

    localparam logic REG_GEN_LIMIT = 1'b0;
    localparam logic REG_REP_LIMIT = 1'b1;

    typedef struct packed {
        logic [CNT_W-1:0]  count;
        logic [LEN_W-1:0]  len;
        logic [SLOT_W-1:0] wptr;
    } t_key_ent;

    // ring slot stepped back by n places, n below HIST_DEPTH
    function automatic logic [SLOT_W-1:0] slot_back(input logic [SLOT_W-1:0] s,
                                                    input logic [2:0] n);
        logic [SLOT_W:0] w;
        w = {1'b0, s} + (SLOT_W+1)'(HIST_DEPTH) - (SLOT_W+1)'(n);
        if (w >= (SLOT_W+1)'(HIST_DEPTH)) begin
            w = w - (SLOT_W+1)'(HIST_DEPTH);
        end
        return w[SLOT_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] hist_addr(input logic [KEY_W-1:0] k,
                                                    input logic [SLOT_W-1:0] s);
        return ADDR_W'(k) * ADDR_W'(HIST_DEPTH) + ADDR_W'(s);
    endfunction

endpackage

### hdl/rw_hist_ram.sv
// rw_hist_ram: single-port synchronous RAM holding the hash history rings.
// Depends on nothing; sized by its parameters.
module rw_hist_ram #(
    parameter int DEPTH  = 4096,
    parameter int WIDTH  = 64,
    parameter int AW     = 12
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

### hdl/rw_key_tbl.sv
// rw_key_tbl: per-key count, history length and write pointer memory.
// Valid bits give the all-zero reset state. Depends on rw_pkg.
module rw_key_tbl (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [rw_pkg::KIDX_W-1:0] i_raddr,
    output rw_pkg::t_key_ent        o_rdata,
    input  logic                    i_we,
    input  logic [rw_pkg::KIDX_W-1:0] i_waddr,
    input  rw_pkg::t_key_ent        i_wdata
);

    rw_pkg::t_key_ent r_mem [rw_pkg::NUM_KEYS];
    logic [rw_pkg::NUM_KEYS-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_we) begin
            r_vld[i_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_vld[i_raddr] ? r_mem[i_raddr] : '0;
    end

endmodule

### hdl/repetition_watchdog.sv
// repetition_watchdog: per-key event counter and repeating-pattern detector.
// A limit fault, a bad key or a short history ends after S_EVAL; otherwise S_LRD/S_LWT load
// the newest entries, S_RD/S_CMP compare the history per period and S_SKIP gives one up.
// One word at a time: the next word is taken the cycle after the result is loaded, and the
// load waits for a free output. Synchronous active-low reset clears counts, lengths
// and pointers at once (valid bits); limits return to 1000 and 3.
module repetition_watchdog (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [rw_pkg::KEY_W-1:0]   i_key_id,
    input  logic [rw_pkg::HASH_W-1:0]  i_code_hash,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [1:0]                 o_status,
    output logic [2:0]                 o_period_found,
    output logic [3:0]                 o_repeat_total,
    output logic [rw_pkg::CNT_W-1:0]   o_event_count,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_EVAL = 8'b0000_0010,
        S_LRD  = 8'b0000_0100,
        S_LWT  = 8'b0000_1000,
        S_RD   = 8'b0001_0000,
        S_CMP  = 8'b0010_0000,
        S_DONE = 8'b0100_0000,
        S_SKIP = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    logic [15:0] r_gen;
    logic [3:0]  r_rep;

    logic [rw_pkg::KEY_W-1:0]  r_key;
    logic [rw_pkg::HASH_W-1:0] r_hash;
    logic [rw_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    logic [rw_pkg::LEN_W-1:0]  r_len, n_len;
    logic [rw_pkg::SLOT_W-1:0] r_newest, n_newest;
    logic [rw_pkg::SLOT_W-1:0] r_slot, n_slot;
    logic [rw_pkg::LEN_W-1:0]  r_end, n_end;
    logic [2:0]                r_per, n_per;
    logic [2:0]                r_j, n_j;
    logic [4:0]                r_match, n_match;
    logic [rw_pkg::HASH_W-1:0] r_nb [5];
    logic [1:0]                r_sts, n_sts;
    logic [2:0]                r_pf, n_pf;
    logic [3:0]                r_tot, n_tot;

    logic [1:0]                r_o_sts;
    logic [2:0]                r_o_pf;
    logic [3:0]                r_o_tot;
    logic [rw_pkg::CNT_W-1:0]  r_o_cnt;
    logic                      r_o_vld;

    rw_pkg::t_key_ent          kt_rdata, kt_wdata;
    logic                      kt_we;
    logic                      hr_we;
    logic [rw_pkg::ADDR_W-1:0] hr_addr;
    logic [rw_pkg::HASH_W-1:0] hr_rdata;

    logic accept, cfg_wr, out_load, key_bad;
    logic [rw_pkg::CNT_W-1:0]  ev_cnt;
    logic [rw_pkg::SLOT_W-1:0] ev_wptr;
    logic [rw_pkg::LEN_W-1:0]  ev_len;
    logic [2:0]                nxt_per;
    logic                      nxt_ok;
    logic [4:0]                match_inc;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = (paddr[2] == rw_pkg::REG_REP_LIMIT) ? {28'd0, r_rep} : {16'd0, r_gen};

    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid && !o_stall;
    assign key_bad = (int'(r_key) >= rw_pkg::NUM_KEYS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen <= 16'd1000;
            r_rep <= 4'd3;
        end else if (cfg_wr) begin
            if (paddr[2] == rw_pkg::REG_GEN_LIMIT) begin
                r_gen <= pwdata[15:0];
            end else begin
                r_rep <= pwdata[3:0];
            end
        end
    end

    rw_key_tbl u_key_tbl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_raddr (rw_pkg::KIDX_W'(i_key_id)),
        .o_rdata (kt_rdata),
        .i_we    (kt_we),
        .i_waddr (rw_pkg::KIDX_W'(r_key)),
        .i_wdata (kt_wdata)
    );

    rw_hist_ram #(
        .DEPTH (rw_pkg::NUM_KEYS * rw_pkg::HIST_DEPTH),
        .WIDTH (rw_pkg::HASH_W),
        .AW    (rw_pkg::ADDR_W)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (hr_we),
        .i_addr  (hr_addr),
        .i_wdata (r_hash),
        .o_rdata (hr_rdata)
    );

    always_comb begin
        ev_cnt  = (kt_rdata.count < rw_pkg::COUNT_SAT) ? kt_rdata.count + 1'b1 : kt_rdata.count;
        ev_wptr = (int'(kt_rdata.wptr) == rw_pkg::HIST_DEPTH - 1) ? '0 : kt_rdata.wptr + 1'b1;
        ev_len  = (int'(kt_rdata.len) < rw_pkg::HIST_DEPTH) ? kt_rdata.len + 1'b1 : kt_rdata.len;
        nxt_per = r_per + 3'd1;
        nxt_ok  = (int'(r_per) < rw_pkg::PERIOD_LAST) &&
                  (rw_pkg::LEN_W'({nxt_per, 1'b0}) <= r_len);
        match_inc = r_match + 5'd1;
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_len    = r_len;
        n_newest = r_newest;
        n_slot   = r_slot;
        n_end    = r_end;
        n_per    = r_per;
        n_j      = r_j;
        n_match  = r_match;
        n_sts    = r_sts;
        n_pf     = r_pf;
        n_tot    = r_tot;
        kt_we    = 1'b0;
        kt_wdata = kt_rdata;
        hr_we    = 1'b0;
        hr_addr  = rw_pkg::hist_addr(r_key, r_slot);
        out_load = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EVAL;
                    n_sts = rw_pkg::ST_OK;
                    n_pf  = '0;
                    n_tot = '0;
                end
            end
            S_EVAL: begin
                if (key_bad) begin
                    n_cnt   = '0;
                    n_state = S_DONE;
                end else begin
                    n_cnt = ev_cnt;
                    kt_we = 1'b1;
                    kt_wdata.count = ev_cnt;
                    if (ev_cnt > rw_pkg::CNT_W'(r_gen)) begin
                        n_sts   = rw_pkg::ST_LIMIT;
                        n_state = S_DONE;
                    end else begin
                        hr_we   = 1'b1;
                        hr_addr = rw_pkg::hist_addr(r_key, kt_rdata.wptr);
                        kt_wdata.wptr = ev_wptr;
                        kt_wdata.len  = ev_len;
                        n_len    = ev_len;
                        n_newest = kt_rdata.wptr;
                        n_slot   = rw_pkg::slot_back(kt_rdata.wptr, 3'd1);
                        n_j      = 3'd1;
                        n_state  = (int'(ev_len) >= rw_pkg::MIN_HISTORY) ? S_LRD : S_DONE;
                    end
                end
            end
            S_LRD: begin
                n_state = S_LWT;
            end
            S_LWT: begin
                if (int'(r_j) == rw_pkg::PERIOD_LAST - 1) begin
                    n_per   = 3'(rw_pkg::PERIOD_FIRST);
                    n_end   = r_len - rw_pkg::LEN_W'(rw_pkg::PERIOD_FIRST);
                    n_slot  = rw_pkg::slot_back(r_newest, 3'(rw_pkg::PERIOD_FIRST));
                    n_j     = '0;
                    n_match = '0;
                    n_state = S_RD;
                end else begin
                    n_j     = r_j + 3'd1;
                    n_slot  = rw_pkg::slot_back(r_slot, 3'd1);
                    n_state = S_LRD;
                end
            end
            S_RD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (hr_rdata != r_nb[r_j]) begin
                    n_state = S_SKIP;
                end else if (r_j == r_per - 3'd1) begin
                    n_match = match_inc;
                    if (match_inc >= {1'b0, r_rep}) begin
                        n_sts   = rw_pkg::ST_PATTERN;
                        n_pf    = r_per;
                        n_tot   = (match_inc >= 5'd15) ? 4'd15 : match_inc[3:0] + 4'd1;
                        n_state = S_DONE;
                    end else begin
                        n_end = r_end - rw_pkg::LEN_W'(r_per);
                        n_j   = '0;
                        n_slot = rw_pkg::slot_back(r_slot, 3'd1);
                        n_state = (r_end - rw_pkg::LEN_W'(r_per) >= rw_pkg::LEN_W'(r_per))
                                  ? S_RD : S_SKIP;
                    end
                end else begin
                    n_j     = r_j + 3'd1;
                    n_slot  = rw_pkg::slot_back(r_slot, 3'd1);
                    n_state = S_RD;
                end
            end
            S_SKIP: begin
                if (nxt_ok) begin
                    n_per   = nxt_per;
                    n_end   = r_len - rw_pkg::LEN_W'(nxt_per);
                    n_slot  = rw_pkg::slot_back(r_newest, nxt_per);
                    n_j     = '0;
                    n_match = '0;
                    n_state = S_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_o_vld || !i_stall) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_o_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_o_vld <= 1'b1;
            end else if (!i_stall) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_key  <= i_key_id;
            r_hash <= i_code_hash;
        end
        if (r_state == S_EVAL) begin
            r_nb[0] <= r_hash;
        end
        if (r_state == S_LWT) begin
            r_nb[r_j] <= hr_rdata;
        end
        r_cnt    <= n_cnt;
        r_len    <= n_len;
        r_newest <= n_newest;
        r_slot   <= n_slot;
        r_end    <= n_end;
        r_per    <= n_per;
        r_j      <= n_j;
        r_match  <= n_match;
        r_sts    <= n_sts;
        r_pf     <= n_pf;
        r_tot    <= n_tot;
        if (out_load) begin
            r_o_sts <= r_sts;
            r_o_pf  <= r_pf;
            r_o_tot <= r_tot;
            r_o_cnt <= r_cnt;
        end
    end

    assign o_valid        = r_o_vld;
    assign o_status       = r_o_sts;
    assign o_period_found = r_o_pf;
    assign o_repeat_total = r_o_tot;
    assign o_event_count  = r_o_cnt;

endmodule
